FILE: src/mandelbrot_escape_pixel_unit_assert.svh
// ----------------------------------------------------------------------------
// mandelbrot escape pixel unit assertion macros
// shared helpers for the concurrent checks, clocked on clk, reset on rst_n
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_PIXEL_UNIT_ASSERT_SVH
`define MANDELBROT_ESCAPE_PIXEL_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MEP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mep_pkg.sv
// ----------------------------------------------------------------------------
// mep_pkg
// widths, constants, types and helpers of the escape time pixel unit
// ----------------------------------------------------------------------------
package mep_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int Q_W        = 32;
  localparam int IDX_W      = 19;
  localparam int ITER_W     = 16;
  localparam int COLOUR_W   = 25;
  localparam int LIMIT_W    = 31;
  localparam int STEP_W     = 30;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = 1;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ESCAPE_LIMIT_SQ = 1'b0;
  localparam cfg_idx_t CFG_ITERATION_CAP   = 1'b1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd1073741824;
  localparam logic [ITER_W-1:0]  CAP_RESET   = 16'd5000;

  // plane origin: -2.0 and -1.0 in Q4.28
  localparam logic signed [63:0] ORIGIN_X = -64'sd536870912;
  localparam logic signed [63:0] ORIGIN_Y = -64'sd268435456;

  typedef struct packed {
    logic signed [Q_W-1:0] cx;
    logic signed [Q_W-1:0] cy;
  } mep_point_t;

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [Q_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: src/mep_in_if.sv
// ----------------------------------------------------------------------------
// mep_in_if
// pixel index channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface mep_in_if;
  import mep_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] pixel_index;

  modport source (output valid, output pixel_index, input ready);
  modport sink (input valid, input pixel_index, output ready);
endinterface

FILE: src/mep_out_if.sv
// ----------------------------------------------------------------------------
// mep_out_if
// result channel carrying iteration count and colour, valid/ready handshake
// ----------------------------------------------------------------------------
interface mep_out_if;
  import mep_pkg::*;

  logic                valid;
  logic                ready;
  logic [ITER_W-1:0]   iterations;
  logic [COLOUR_W-1:0] colour;

  modport source (output valid, output iterations, output colour, input ready);
  modport sink (input valid, input iterations, input colour, output ready);
endinterface

FILE: src/mep_front.sv
// ----------------------------------------------------------------------------
// mep_front
// splits the pixel index into column and row, maps them onto the plane
// ----------------------------------------------------------------------------
module mep_front #(
  parameter int WIDTH  = 640,
  parameter int HEIGHT = 480
) (
  input  logic                clk,
  input  logic                rst_n,
  mep_in_if.sink              in_px,
  output mep_pkg::mep_point_t pt,
  output logic                pt_valid,
  input  logic                pt_ready
);
  import mep_pkg::*;

  localparam int ROW_W  = $clog2(HEIGHT);
  localparam int RCP_SH = IDX_W + ROW_W;
  localparam int RCP_W  = IDX_W + 1;
  localparam int PROD_W = IDX_W + RCP_W;
  localparam int PX_W   = IDX_W + STEP_W;
  localparam int PY_W   = ROW_W + STEP_W;
  // reciprocal of the height, exact for every index width value
  localparam longint RCP = ((longint'(1) << RCP_SH) + HEIGHT - 1) / HEIGHT;
  localparam logic [RCP_W-1:0] RCP_V    = RCP_W'(RCP);
  localparam logic [IDX_W-1:0] HEIGHT_V = IDX_W'(HEIGHT);
  localparam longint PD_X = (3 * (longint'(1) << FRAC_BITS) + WIDTH / 2) / WIDTH;
  localparam longint PD_Y = (2 * (longint'(1) << FRAC_BITS) + HEIGHT / 2) / HEIGHT;
  localparam logic [STEP_W-1:0] PD_X_V = STEP_W'(PD_X);
  localparam logic [STEP_W-1:0] PD_Y_V = STEP_W'(PD_Y);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_DIV  = 5'b00010,
    F_ROW  = 5'b00100,
    F_MUL  = 5'b01000,
    F_PUSH = 5'b10000
  } f_state_t;

  f_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  rem_r, rem_nxt;
  logic [PX_W-1:0]   px_r, px_nxt;
  logic [PY_W-1:0]   py_r, py_nxt;
  logic [PROD_W-1:0] rcp_prod;
  logic [IDX_W-1:0]  col_back;
  logic [IDX_W-1:0]  row_full;

  // column by reciprocal multiply, row as what is left over
  assign rcp_prod = PROD_W'(idx_r) * PROD_W'(RCP_V);
  assign col_back = col_r * HEIGHT_V;
  assign row_full = idx_r - col_back;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    col_nxt   = col_r;
    rem_nxt   = rem_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_px.valid) begin
          idx_nxt   = in_px.pixel_index;
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        col_nxt   = IDX_W'(rcp_prod >> RCP_SH);
        state_nxt = F_ROW;
      end
      F_ROW: begin
        rem_nxt   = row_full[ROW_W-1:0];
        px_nxt    = PX_W'(col_r) * PX_W'(PD_X_V);
        state_nxt = F_MUL;
      end
      F_MUL: begin
        py_nxt    = PY_W'(rem_r) * PY_W'(PD_Y_V);
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (pt_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    col_r <= col_nxt;
    rem_r <= rem_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
  end

  assign in_px.ready = (state_r == F_IDLE);
  assign pt_valid    = (state_r == F_PUSH);
  assign pt.cx = sat32(ORIGIN_X + $signed({{(64-PX_W){1'b0}}, px_r}));
  assign pt.cy = sat32(ORIGIN_Y + $signed({{(64-PY_W){1'b0}}, py_r}));

endmodule

FILE: src/mep_queue.sv
// ----------------------------------------------------------------------------
// mep_queue
// two entry queue of plane points between front and back
// ----------------------------------------------------------------------------
module mep_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  mep_pkg::mep_point_t wr_pt,
  input  logic                wr_valid,
  output logic                wr_ready,
  output mep_pkg::mep_point_t rd_pt,
  output logic                rd_valid,
  input  logic                rd_ready
);
  import mep_pkg::*;

  mep_point_t        entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              push, pop;

  assign wr_ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_pt    = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_pt;
    end
  end

endmodule

FILE: src/mep_back.sv
// ----------------------------------------------------------------------------
// mep_back
// escape time iteration, serial colour divide and the result register
// ----------------------------------------------------------------------------
module mep_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mep_pkg::mep_point_t           pt,
  input  logic                          pt_valid,
  output logic                          pt_ready,
  input  logic [mep_pkg::LIMIT_W-1:0]   limit,
  input  logic [mep_pkg::ITER_W-1:0]    cap,
  mep_out_if.source                     out_res
);
  import mep_pkg::*;

  localparam int DIV_N = ITER_W + 24;
  localparam int DCNT_W = $clog2(DIV_N);
  localparam logic signed [63:0] HALF_X = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] HALF_Y = 64'sd1 <<< (FRAC_BITS - 2);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_MUL  = 5'b00010,
    B_TEST = 5'b00100,
    B_DIV  = 5'b01000,
    B_OUT  = 5'b10000
  } b_state_t;

  b_state_t              state_r, state_nxt;
  logic signed [Q_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [Q_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [63:0]    xx_r, xx_nxt, yy_r, yy_nxt, xy_r, xy_nxt;
  logic [ITER_W-1:0]     iter_r, iter_nxt;
  logic [DIV_N-1:0]      dq_r, dq_nxt;
  logic [ITER_W-1:0]     drem_r, drem_nxt;
  logic [DCNT_W-1:0]     dcnt_r, dcnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ITER_W-1:0]     out_iter_r, out_iter_nxt;
  logic [COLOUR_W-1:0]   out_col_r, out_col_nxt;

  logic [63:0]           mag;
  logic [63:0]           limit_ext;
  logic                  go;
  logic [ITER_W:0]       dtrial, dtrial_sub;
  logic                  dge;
  logic                  out_free;

  // exact sum of squares against the limit scaled to Q8.56
  assign mag       = $unsigned(xx_r) + $unsigned(yy_r);
  assign limit_ext = {{(64-LIMIT_W-FRAC_BITS){1'b0}}, limit, {FRAC_BITS{1'b0}}};
  assign go        = (mag <= limit_ext) && (iter_r < cap);

  assign dtrial     = {drem_r, dq_r[DIV_N-1]};
  assign dge        = (dtrial >= {1'b0, cap});
  assign dtrial_sub = dtrial - {1'b0, cap};

  assign out_free = !out_valid_r || out_res.ready;

  always_comb begin
    state_nxt     = state_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    xx_nxt        = xx_r;
    yy_nxt        = yy_r;
    xy_nxt        = xy_r;
    iter_nxt      = iter_r;
    dq_nxt        = dq_r;
    drem_nxt      = drem_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    out_iter_nxt  = out_iter_r;
    out_col_nxt   = out_col_r;
    unique case (state_r)
      B_IDLE: begin
        if (pt_valid) begin
          cx_nxt    = pt.cx;
          cy_nxt    = pt.cy;
          x_nxt     = '0;
          y_nxt     = '0;
          iter_nxt  = '0;
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        xx_nxt    = x_r * x_r;
        yy_nxt    = y_r * y_r;
        xy_nxt    = x_r * y_r;
        state_nxt = B_TEST;
      end
      B_TEST: begin
        if (go) begin
          x_nxt     = sat32((((xx_r - yy_r) + HALF_X) >>> FRAC_BITS) + cx_r);
          y_nxt     = sat32(((xy_r + HALF_Y) >>> (FRAC_BITS - 1)) + cy_r);
          iter_nxt  = iter_r + 1'b1;
          state_nxt = B_MUL;
        end else begin
          // a zero cap never iterates, colour stays zero
          dq_nxt    = (cap == '0) ? '0 : {iter_r, 24'b0};
          drem_nxt  = '0;
          dcnt_nxt  = '0;
          state_nxt = (cap == '0) ? B_OUT : B_DIV;
        end
      end
      B_DIV: begin
        drem_nxt = dge ? dtrial_sub[ITER_W-1:0] : dtrial[ITER_W-1:0];
        dq_nxt   = {dq_r[DIV_N-2:0], dge};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCNT_W'(DIV_N - 1)) begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_iter_nxt  = iter_r;
          out_col_nxt   = dq_r[COLOUR_W-1:0];
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    xx_r       <= xx_nxt;
    yy_r       <= yy_nxt;
    xy_r       <= xy_nxt;
    iter_r     <= iter_nxt;
    dq_r       <= dq_nxt;
    drem_r     <= drem_nxt;
    dcnt_r     <= dcnt_nxt;
    out_iter_r <= out_iter_nxt;
    out_col_r  <= out_col_nxt;
  end

  assign pt_ready           = (state_r == B_IDLE);
  assign out_res.valid      = out_valid_r;
  assign out_res.iterations = out_iter_r;
  assign out_res.colour     = out_col_r;

endmodule

FILE: src/mandelbrot_escape_pixel_unit.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_unit
// escape time evaluator for one pixel: index in, iteration count and colour out
// ----------------------------------------------------------------------------
//
//   channel  | dir | payload                         | handshake
//   ---------+-----+---------------------------------+-------------------------
//   in_px    | in  | pixel_index[18:0]               | valid/ready
//   out_res  | out | iterations[15:0], colour[24:0]  | valid/ready
//   cfg      | in  | cfg_index[0], cfg_data[30:0]    | cfg_we, no back pressure
//
// front: accept state, reciprocal multiply for the column, then the row and
//   x offset, then the y offset, then push (held while the queue is full),
//   overlapped with the back through a 2-entry queue
// back: load, then per iteration a multiply state and a test and update state,
//   then the final multiply and test, a serial colour divide and the result load
//   (with a zero cap the colour divide is skipped)
// the iteration loop of the back sets the rate
// reset (rst_n low, synchronous) empties the queue, idles both engines and
//   restores escape_limit_sq = 4.0 and iteration_cap = 5000
// a stalled result sits in the output register while the back runs the next point
//
module mandelbrot_escape_pixel_unit #(
  parameter int WIDTH  = 640,
  parameter int HEIGHT = 480
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mep_in_if.sink                          in_px,
  mep_out_if.source                       out_res,
  input  logic                            cfg_we,
  input  mep_pkg::cfg_idx_t               cfg_index,
  input  logic [mep_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mep_pkg::*;

  // configuration registers
  logic [LIMIT_W-1:0] limit_r;
  logic [ITER_W-1:0]  cap_r;

  // front to queue
  mep_point_t f_pt;
  logic       f_valid, f_ready;

  // queue to back
  mep_point_t q_pt;
  logic       q_valid, q_ready;

  // user must land register writes only while idle; not enforced, so no shadowing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      cap_r   <= CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ESCAPE_LIMIT_SQ: limit_r <= cfg_data[LIMIT_W-1:0];
        CFG_ITERATION_CAP:   cap_r   <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // index to plane point
  mep_front #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_px    (in_px),
    .pt       (f_pt),
    .pt_valid (f_valid),
    .pt_ready (f_ready)
  );

  // decouples point mapping from the iteration loop
  mep_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_pt    (f_pt),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_pt    (q_pt),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  // iteration, colour divide and result register
  mep_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pt       (q_pt),
    .pt_valid (q_valid),
    .pt_ready (q_ready),
    .limit    (limit_r),
    .cap      (cap_r),
    .out_res  (out_res)
  );

endmodule

FILE: src/mep_checker.sv
// ----------------------------------------------------------------------------
// mep_checker
// port level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_pixel_unit_assert.svh"

module mep_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mep_pkg::ITER_W-1:0]     out_iterations,
  input logic [mep_pkg::COLOUR_W-1:0]   out_colour
);
  import mep_pkg::*;

  `MEP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `MEP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_iterations) && $stable(out_colour), "result changed while stalled")
  `MEP_ASSERT_NOW(a_colour_max, out_valid, out_colour <= 25'h1000000, "colour above full scale")
  `MEP_ASSERT_NOW(a_zero_iter, out_valid && (out_iterations == '0), out_colour == '0, "colour nonzero with zero iterations")

endmodule

bind mandelbrot_escape_pixel_unit mep_checker u_mep_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .out_iterations (out_res.iterations),
  .out_colour     (out_res.colour)
);
